@@ rtl/srs_pkg.sv @@
// srs_pkg: shared types, codes and constants of the shadow register sync block
// used by every rtl file of the block, no dependencies of its own
package srs_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 16;
    localparam int CNT_W       = 6;
    localparam int KIND_W      = 4;
    localparam int CMD_W       = 3;
    localparam int CD_W        = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CD_W-1:0] LINK_RELOAD = CD_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INP_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INP_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COIL_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COIL_COUNT = 3'd5;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOCAL_WR     = 4'd0,
        KIND_REMOTE_HOLD  = 4'd1,
        KIND_REMOTE_INPUT = 4'd2,
        KIND_REMOTE_COIL  = 4'd3,
        KIND_ERROR        = 4'd4,
        KIND_SYNC         = 4'd5,
        KIND_RD_HOLD      = 4'd6,
        KIND_RD_INPUT     = 4'd7,
        KIND_RD_COIL      = 4'd8
    } kind_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACK          = 3'd0,
        CMD_WR_SINGLE    = 3'd1,
        CMD_WR_MULTI     = 3'd2,
        CMD_RD_HOLD_REQ  = 3'd3,
        CMD_RD_INPUT_REQ = 3'd4,
        CMD_RD_COIL_REQ  = 3'd5,
        CMD_RD_DATA      = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] reg_address;
        logic [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        cmd_t              command;
        logic [ADDR_W-1:0] start_address;
        logic [CNT_W-1:0]  word_count;
        logic [DATA_W-1:0] word_value;
        logic              link_valid;
        logic              last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP,
        ST_SCAN,
        ST_RUN_LEN,
        ST_RUN_RD,
        ST_RUN_EMIT,
        ST_REQ_HOLD,
        ST_REQ_INPUT,
        ST_REQ_COIL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic finish_op;
        logic scan_skip;
        logic run_begin;
        logic run_grow;
        logic emit_load;
        logic rd_emit;
        logic emit_word;
        logic load_req;
        cmd_t req_cmd;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_sync;
        logic out_free;
        logic scan_end;
        logic scan_dirty;
        logic emit_last;
    } ctrl_status_t;

endpackage

@@ rtl/srs_ctrl.sv @@
// srs_ctrl: sequencing state machine of the shadow register sync block
// depends on srs_pkg; drives srs_datapath through command and status structs
module srs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  srs_pkg::ctrl_status_t status,
    output srs_pkg::ctrl_cmd_t    cmd
);
    import srs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.req_cmd = CMD_RD_HOLD_REQ;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = status.in_sync ? ST_SCAN : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.finish_op = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (status.scan_end) begin
                    state_next = ST_REQ_HOLD;
                end else if (status.scan_dirty) begin
                    cmd.run_begin = 1'b1;
                    state_next    = ST_RUN_LEN;
                end else begin
                    cmd.scan_skip = 1'b1;
                end
            end
            ST_RUN_LEN: begin
                // extend the run until a clean entry or the end of the table
                if (status.scan_dirty) begin
                    cmd.run_grow = 1'b1;
                end else begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_RUN_RD;
                end
            end
            ST_RUN_RD: begin
                cmd.rd_emit = 1'b1;
                state_next  = ST_RUN_EMIT;
            end
            ST_RUN_EMIT: begin
                // keep reading the same entry while the result register is busy
                cmd.rd_emit = 1'b1;
                if (status.out_free) begin
                    cmd.emit_word = 1'b1;
                    state_next    = status.emit_last ? ST_SCAN : ST_RUN_RD;
                end
            end
            ST_REQ_HOLD: begin
                cmd.req_cmd = CMD_RD_HOLD_REQ;
                if (status.out_free) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_REQ_INPUT;
                end
            end
            ST_REQ_INPUT: begin
                cmd.req_cmd = CMD_RD_INPUT_REQ;
                if (status.out_free) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_REQ_COIL;
                end
            end
            ST_REQ_COIL: begin
                cmd.req_cmd = CMD_RD_COIL_REQ;
                if (status.out_free) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/srs_datapath.sv @@
// srs_datapath: register stores, dirty flags, sync scan counters and result register
// depends on srs_pkg; sequenced by srs_ctrl
module srs_datapath #(
    parameter int DEPTH = srs_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  srs_pkg::in_item_t               s_data,
    output srs_pkg::out_item_t              m_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  srs_pkg::ctrl_cmd_t              cmd,
    output srs_pkg::ctrl_status_t           status
);
    import srs_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // configuration
    logic [ADDR_W-1:0] hold_base_reg, inp_base_reg, coil_base_reg;
    logic [CNT_W-1:0]  hold_count_reg, inp_count_reg, coil_count_reg;
    logic [CNT_W-1:0]  hold_eff, inp_eff, coil_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_base_reg  <= '0;
            hold_count_reg <= '0;
            inp_base_reg   <= '0;
            inp_count_reg  <= '0;
            coil_base_reg  <= '0;
            coil_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HOLD_BASE:  hold_base_reg  <= cfg_wdata[ADDR_W-1:0];
                CFG_HOLD_COUNT: hold_count_reg <= cfg_wdata[CNT_W-1:0];
                CFG_INP_BASE:   inp_base_reg   <= cfg_wdata[ADDR_W-1:0];
                CFG_INP_COUNT:  inp_count_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_COIL_BASE:  coil_base_reg  <= cfg_wdata[ADDR_W-1:0];
                CFG_COIL_COUNT: coil_count_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign hold_eff = (hold_count_reg > DEPTH_C) ? DEPTH_C : hold_count_reg;
    assign inp_eff  = (inp_count_reg  > DEPTH_C) ? DEPTH_C : inp_count_reg;
    assign coil_eff = (coil_count_reg > DEPTH_C) ? DEPTH_C : coil_count_reg;

    // address decode of the incoming request
    logic [ADDR_W-1:0] sel_base;
    logic [CNT_W-1:0]  sel_cnt;
    logic [ADDR_W:0]   diff;
    logic              hit_next;

    always_comb begin
        sel_base = hold_base_reg;
        sel_cnt  = hold_eff;
        case (s_data.kind) inside
            KIND_REMOTE_INPUT, KIND_RD_INPUT: begin
                sel_base = inp_base_reg;
                sel_cnt  = inp_eff;
            end
            KIND_REMOTE_COIL, KIND_RD_COIL: begin
                sel_base = coil_base_reg;
                sel_cnt  = coil_eff;
            end
            default: ;
        endcase
        diff     = {1'b0, s_data.reg_address} - {1'b0, sel_base};
        hit_next = !diff[ADDR_W]
                   && (diff[ADDR_W-1:0] < {{(ADDR_W-CNT_W){1'b0}}, sel_cnt});
    end

    in_item_t          item_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [CD_W-1:0]   cd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
            hit_reg  <= hit_next;
            slot_reg <= diff[IDX_W-1:0];
        end
    end

    // link validity countdown
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cd_reg <= '0;
        end else if (cmd.capture) begin
            if (s_data.kind == KIND_REMOTE_COIL) begin
                cd_reg <= LINK_RELOAD;
            end else if (s_data.kind == KIND_ERROR && cd_reg != '0) begin
                cd_reg <= cd_reg - CD_W'(1);
            end
        end
    end

    // sync scan counters
    logic [CW-1:0] scan_idx_reg, run_start_reg, run_len_reg, emit_idx_reg;
    logic [CW-1:0] emit_idx_inc;

    assign emit_idx_inc = emit_idx_reg + CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg  <= '0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            emit_idx_reg  <= '0;
        end else begin
            if (cmd.capture) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan_skip || cmd.run_begin || cmd.run_grow) begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            if (cmd.run_begin) begin
                run_start_reg <= scan_idx_reg;
                run_len_reg   <= CW'(1);
            end else if (cmd.run_grow) begin
                run_len_reg <= run_len_reg + CW'(1);
            end
            if (cmd.emit_load) begin
                emit_idx_reg <= run_start_reg;
            end else if (cmd.emit_word) begin
                emit_idx_reg <= emit_idx_inc;
            end
        end
    end

    // stores, each entry reads as zero until first written
    logic [DATA_W-1:0] hold_mem [DEPTH];
    logic [DATA_W-1:0] shad_mem [DEPTH];
    logic [DATA_W-1:0] inp_mem  [DEPTH];
    logic              coil_mem [DEPTH];
    logic [DEPTH-1:0]  hold_vld_reg, shad_vld_reg, inp_vld_reg, coil_vld_reg;
    logic [DEPTH-1:0]  dirty_reg;

    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] hold_rd_reg, shad_rd_reg, inp_rd_reg;
    logic              coil_rd_reg;
    logic              hold_rdv_reg, shad_rdv_reg, inp_rdv_reg, coil_rdv_reg;
    logic [DATA_W-1:0] hold_word, shad_word, inp_word;
    logic              coil_bit;

    assign rd_idx = cmd.rd_emit ? emit_idx_reg[IDX_W-1:0] : slot_reg;

    always_ff @(posedge aclk) begin
        hold_rd_reg  <= hold_mem[rd_idx];
        shad_rd_reg  <= shad_mem[rd_idx];
        inp_rd_reg   <= inp_mem[rd_idx];
        coil_rd_reg  <= coil_mem[rd_idx];
        hold_rdv_reg <= hold_vld_reg[rd_idx];
        shad_rdv_reg <= shad_vld_reg[rd_idx];
        inp_rdv_reg  <= inp_vld_reg[rd_idx];
        coil_rdv_reg <= coil_vld_reg[rd_idx];
    end

    assign hold_word = hold_rdv_reg ? hold_rd_reg : '0;
    assign shad_word = shad_rdv_reg ? shad_rd_reg : '0;
    assign inp_word  = inp_rdv_reg  ? inp_rd_reg  : '0;
    assign coil_bit  = coil_rdv_reg & coil_rd_reg;

    // write enables; dirty marks holding != shadow
    logic op_hit, remote_take;
    logic hold_we, shad_we, inp_we, coil_we;
    logic [IDX_W-1:0]  shad_idx;
    logic [DATA_W-1:0] shad_wd;

    assign op_hit      = cmd.finish_op && hit_reg;
    assign remote_take = op_hit && item_reg.kind == KIND_REMOTE_HOLD && !dirty_reg[slot_reg];
    assign hold_we     = (op_hit && item_reg.kind == KIND_LOCAL_WR) || remote_take;
    assign shad_we     = remote_take || cmd.emit_word;
    assign shad_idx    = cmd.emit_word ? emit_idx_reg[IDX_W-1:0] : slot_reg;
    assign shad_wd     = cmd.emit_word ? hold_word : item_reg.value;
    assign inp_we      = op_hit && item_reg.kind == KIND_REMOTE_INPUT;
    assign coil_we     = op_hit && item_reg.kind == KIND_REMOTE_COIL;

    always_ff @(posedge aclk) begin
        if (hold_we) begin
            hold_mem[slot_reg] <= item_reg.value;
        end
        if (shad_we) begin
            shad_mem[shad_idx] <= shad_wd;
        end
        if (inp_we) begin
            inp_mem[slot_reg] <= item_reg.value;
        end
        if (coil_we) begin
            coil_mem[slot_reg] <= item_reg.value[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= '0;
            shad_vld_reg <= '0;
            inp_vld_reg  <= '0;
            coil_vld_reg <= '0;
            dirty_reg    <= '0;
        end else begin
            if (hold_we) begin
                hold_vld_reg[slot_reg] <= 1'b1;
            end
            if (shad_we) begin
                shad_vld_reg[shad_idx] <= 1'b1;
            end
            if (inp_we) begin
                inp_vld_reg[slot_reg] <= 1'b1;
            end
            if (coil_we) begin
                coil_vld_reg[slot_reg] <= 1'b1;
            end
            if (op_hit && item_reg.kind == KIND_LOCAL_WR) begin
                dirty_reg[slot_reg] <= (item_reg.value != shad_word);
            end
            if (cmd.emit_word) begin
                dirty_reg[emit_idx_reg[IDX_W-1:0]] <= 1'b0;
            end
        end
    end

    // result formation
    logic [DATA_W-1:0] rd_word;
    out_item_t         res;
    logic              load;
    out_item_t         m_data_reg;
    logic              m_valid_reg;

    always_comb begin
        case (item_reg.kind) inside
            KIND_RD_INPUT: rd_word = inp_word;
            KIND_RD_COIL:  rd_word = {{(DATA_W-1){1'b0}}, coil_bit};
            default:       rd_word = hold_word;
        endcase
    end

    always_comb begin
        res.command       = CMD_ACK;
        res.start_address = item_reg.reg_address;
        res.word_count    = '0;
        res.word_value    = '0;
        res.link_valid    = (cd_reg != '0);
        res.last          = 1'b1;
        if (cmd.emit_word) begin
            res.command       = (run_len_reg == CW'(1)) ? CMD_WR_SINGLE : CMD_WR_MULTI;
            res.start_address = hold_base_reg + ADDR_W'(run_start_reg);
            res.word_count    = CNT_W'(run_len_reg);
            res.word_value    = hold_word;
            res.last          = 1'b0;
        end else if (cmd.load_req) begin
            res.command = cmd.req_cmd;
            res.last    = (cmd.req_cmd == CMD_RD_COIL_REQ);
            case (cmd.req_cmd)
                CMD_RD_INPUT_REQ: begin
                    res.start_address = inp_base_reg;
                    res.word_count    = inp_eff;
                end
                CMD_RD_COIL_REQ: begin
                    res.start_address = coil_base_reg;
                    res.word_count    = coil_eff;
                end
                default: begin
                    res.start_address = hold_base_reg;
                    res.word_count    = hold_eff;
                end
            endcase
        end else if (item_reg.kind == KIND_RD_HOLD || item_reg.kind == KIND_RD_INPUT
                     || item_reg.kind == KIND_RD_COIL) begin
            res.command    = CMD_RD_DATA;
            res.word_count = CNT_W'(1);
            res.word_value = hit_reg ? rd_word : '0;
        end
    end

    assign load = cmd.finish_op || cmd.emit_word || cmd.load_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= res;
        end
    end

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

    // status back to the controller
    always_comb begin
        status.in_sync    = (s_data.kind == KIND_SYNC);
        status.out_free   = !m_valid_reg || m_ready;
        status.scan_end   = (CNT_W'(scan_idx_reg) >= hold_eff);
        status.scan_dirty = !status.scan_end && dirty_reg[scan_idx_reg[IDX_W-1:0]];
        status.emit_last  = (emit_idx_inc == scan_idx_reg);
    end

endmodule

@@ rtl/shadow_register_sync.sv @@
// shadow_register_sync: top level of the remote register map mirror
// depends on srs_pkg, srs_ctrl and srs_datapath
//
// Requests enter on the s_ channel (valid/ready) and results leave on the m_
// channel (valid/ready); a result register sits between the two sides, so a
// new request is taken while the previous result still waits on m_ready.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while idle.
// Every request except sync gives one result with last set. An ordinary
// request passes through a memory read state and a read-modify-write state
// on the holding, shadow, input and coil stores, each with a single write
// port; its result is registered as the read-modify-write state completes.
// A sync walks the holding table one entry a cycle, pausing at each run of
// changed entries to emit it, one read and one emit state per written word,
// the emit waiting while the result register is busy; then it emits three
// read requests, the last one flagged.
// Reset clears all configuration, store valid bits, countdown and result valid
// at once; stores use per-entry valid bits, so there is no clearing pass.
// A stalled receiver holds the result register and the sequencer waits,
// so backpressure reaches s_ready within one request.
module shadow_register_sync #(
    parameter int DEPTH = srs_pkg::DEPTH_DEF  // 1 to 63
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  srs_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output srs_pkg::out_item_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import srs_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    srs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    srs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ rtl/srs_checker.sv @@
// srs_checker: port-level assertions for shadow_register_sync, bound to the top level
// depends on srs_pkg
module srs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input srs_pkg::out_item_t             m_data
);
    import srs_pkg::*;

    // one request in work at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after a request was taken");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_read_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.command == CMD_RD_DATA
        |-> m_data.last && m_data.word_count == CNT_W'(1))
        else $error("read data result malformed");

    // writes never end a sync, the coil read request does
    a_write_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.command == CMD_WR_SINGLE || m_data.command == CMD_WR_MULTI)
        |-> !m_data.last && m_data.word_count != '0)
        else $error("write result malformed");

endmodule

bind shadow_register_sync srs_checker u_srs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
